FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle, outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle, outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle, checked through reset as well.
`define ASSERT_NEXT_ANY(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/pic_pkg.sv
// Shared types and constants of the piecewise-constant interpolator.
package pic_pkg;

    // Table size and derived widths.
    localparam int MAX_POINTS = 64;
    localparam int N_CELLS    = MAX_POINTS + 1;
    localparam int IDX_W      = $clog2(MAX_POINTS + 2);
    localparam int CNT_W      = $clog2(N_CELLS + 1);
    localparam int DATA_W     = 32;
    localparam int BX_W       = 34;

    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [BX_W-1:0]   t_bx;

    // Action codes of an input item.
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_TABLE = 2'd1,
        ST_DROPPED  = 2'd2
    } t_status;

    // Table write bus broadcast to every cell.
    // Port a writes boundary and level at one index, port b a level only,
    // port c the first boundary, port d the closing boundary.
    typedef struct packed {
        logic  a_en;
        t_idx  a_idx;
        t_bx   a_bx;
        t_data a_ly;
        logic  b_en;
        t_idx  b_idx;
        t_data b_ly;
        logic  c_en;
        t_bx   c_bx;
        logic  d_en;
        t_idx  d_idx;
        t_bx   d_bx;
    } t_wr;

    // Query token that travels down the cell chain.
    typedef struct packed {
        logic    valid;
        t_data   x;
        t_data   level;
        t_status status;
    } t_tok;

endpackage

FILE: rtl/core/piecewise_constant_interpolator_top.sv
// Piecewise-constant interpolator: a query passes through each registered cell
// of the table chain in turn and then through the output register.
// Queries enter one per cycle while the output is not stalled.
// A load is accepted once no query is left in the chain.
// Synchronous active-low reset empties the chain and drops any loaded table.
module piecewise_constant_interpolator_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_action,
    input  logic signed [31:0]   i_x_value,
    input  logic signed [31:0]   i_y_value,
    input  logic                 i_last_point,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [31:0]   o_level,
    output logic [1:0]           o_status
);
    import pic_pkg::*;

    logic    adv;
    logic    load_acc;
    logic    query_acc;
    t_wr     wr;
    t_status q_status;
    t_idx    entries;
    t_tok    tok [N_CELLS+1];
    t_cnt    r_inflight;
    logic    r_out_valid;
    t_data   r_level;
    t_status r_status;
    logic    leave;

    // The chain moves whenever the output register can take a result.
    always_comb begin
        adv        = !r_out_valid || i_out_ready;
        o_in_ready = (i_action == ACT_QUERY) ? adv : (r_inflight == '0);
        load_acc   = i_in_valid && o_in_ready && (i_action == ACT_LOAD);
        query_acc  = i_in_valid && o_in_ready && (i_action == ACT_QUERY);
        leave      = adv && tok[N_CELLS].valid;
    end

    pic_loader u_loader (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (load_acc),
        .i_x       (i_x_value),
        .i_y       (i_y_value),
        .i_last    (i_last_point),
        .o_wr      (wr),
        .o_status  (q_status),
        .o_entries (entries)
    );

    // A new query token enters the first cell with a zero level.
    assign tok[0] = '{valid: query_acc, x: i_x_value, level: '0, status: q_status};

    // Row of table cells.
    for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
        pic_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_index   (t_idx'(k)),
            .i_adv     (adv),
            .i_wr      (wr),
            .i_entries (entries),
            .i_tok     (tok[k]),
            .o_tok     (tok[k+1])
        );
    end

    // Count of queries inside the chain, so that loads wait for them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else if (query_acc && !leave) begin
            r_inflight <= r_inflight + t_cnt'(1);
        end else if (leave && !query_acc) begin
            r_inflight <= r_inflight - t_cnt'(1);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= tok[N_CELLS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (leave) begin
            r_level  <= tok[N_CELLS].level;
            r_status <= tok[N_CELLS].status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_level     = r_level;
    assign o_status    = r_status;

endmodule

FILE: rtl/core/pic_loader.sv
// Table builder: tracks the load sequence and drives the table write bus.
module pic_loader (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  pic_pkg::t_data i_x,
    input  pic_pkg::t_data i_y,
    input  logic           i_last,
    output pic_pkg::t_wr   o_wr,
    output pic_pkg::t_status o_status,
    output pic_pkg::t_idx  o_entries
);
    import pic_pkg::*;

    t_idx  r_points, n_points;
    t_data r_px, n_px;
    t_data r_bpx, n_bpx;
    t_data r_py;
    logic  r_ready;
    logic  r_ovf, n_ovf;

    t_idx  base_n;
    logic  fresh;
    logic  stored;
    logic signed [DATA_W:0]   mid_sum;
    logic signed [DATA_W:0]   avg_sum;
    logic signed [DATA_W+2:0] c_sum;
    logic signed [DATA_W+2:0] d_sum;
    logic signed [DATA_W+2:0] px_ext;
    logic signed [DATA_W+2:0] x_ext;
    logic signed [DATA_W+2:0] pxn_ext;
    logic signed [DATA_W+2:0] bpxn_ext;

    // A load while a table is held starts a new sequence.
    always_comb begin
        fresh  = r_ready;
        base_n = fresh ? '0 : r_points;
        stored = (base_n < t_idx'(MAX_POINTS));
        n_ovf  = (fresh ? 1'b0 : r_ovf) | ~stored;
        n_points = stored ? base_n + t_idx'(1) : base_n;
        n_px   = stored ? i_x  : r_px;
        n_bpx  = stored ? r_px : r_bpx;
    end

    // Midpoints, averages and the extrapolated half-steps, each halved by
    // dropping the low bit, which rounds toward minus infinity.
    always_comb begin
        mid_sum  = {r_px[DATA_W-1], r_px} + {i_x[DATA_W-1], i_x};
        avg_sum  = {r_py[DATA_W-1], r_py} + {i_y[DATA_W-1], i_y};
        px_ext   = {{3{r_px[DATA_W-1]}}, r_px};
        x_ext    = {{3{i_x[DATA_W-1]}}, i_x};
        pxn_ext  = {{3{n_px[DATA_W-1]}}, n_px};
        bpxn_ext = {{3{n_bpx[DATA_W-1]}}, n_bpx};
        c_sum    = px_ext + px_ext + px_ext - x_ext;
        d_sum    = pxn_ext + pxn_ext + pxn_ext - bpxn_ext;
    end

    // Write bus for the current load item.
    always_comb begin
        o_wr       = '0;
        o_wr.a_idx = base_n;
        o_wr.b_idx = base_n + t_idx'(1);
        o_wr.b_ly  = i_y;
        o_wr.d_idx = n_points;
        o_wr.c_bx  = c_sum[DATA_W+2:1];
        o_wr.d_bx  = d_sum[DATA_W+2:1];
        if (base_n == '0) begin
            o_wr.a_bx = {{(BX_W-DATA_W){i_x[DATA_W-1]}}, i_x};
            o_wr.a_ly = i_y;
        end else begin
            o_wr.a_bx = {{(BX_W-DATA_W){mid_sum[DATA_W]}}, mid_sum[DATA_W:1]};
            o_wr.a_ly = avg_sum[DATA_W:1];
        end
        if (i_load) begin
            o_wr.a_en = stored;
            o_wr.b_en = stored;
            o_wr.c_en = stored && (base_n == t_idx'(1));
            o_wr.d_en = i_last && (n_points >= t_idx'(2));
        end
    end

    // Sequence state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= '0;
            r_px     <= '0;
            r_bpx    <= '0;
            r_ready  <= 1'b0;
            r_ovf    <= 1'b0;
        end else if (i_load) begin
            r_points <= n_points;
            r_px     <= n_px;
            r_bpx    <= n_bpx;
            r_ready  <= i_last;
            r_ovf    <= n_ovf;
        end
    end

    // Raw sample value of the previous point, averaged with the next one.
    always_ff @(posedge i_clk) begin
        if (i_load && stored) begin
            r_py <= i_y;
        end
    end

    // Status and active entry count seen by a query.
    always_comb begin
        if (!r_ready || r_points == '0) begin
            o_status = ST_NO_TABLE;
        end else if (r_ovf) begin
            o_status = ST_DROPPED;
        end else begin
            o_status = ST_OK;
        end
        o_entries = (r_points == t_idx'(1)) ? t_idx'(1) : r_points + t_idx'(1);
    end

endmodule

FILE: rtl/core/pic_cell.sv
// One table cell: holds a boundary and its level and updates a passing query.
module pic_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pic_pkg::t_idx i_index,
    input  logic          i_adv,
    input  pic_pkg::t_wr  i_wr,
    input  pic_pkg::t_idx i_entries,
    input  pic_pkg::t_tok i_tok,
    output pic_pkg::t_tok o_tok
);
    import pic_pkg::*;

    t_bx     r_bx;
    t_data   r_ly;
    logic    r_valid;
    t_data   r_x;
    t_data   r_level;
    t_status r_status;

    t_bx   x_ext;
    logic  take;
    t_data n_level;

    // Table entry writes addressed by index.
    always_ff @(posedge i_clk) begin
        if (i_wr.a_en && i_wr.a_idx == i_index) begin
            r_bx <= i_wr.a_bx;
        end else if (i_wr.c_en && i_index == '0) begin
            r_bx <= i_wr.c_bx;
        end else if (i_wr.d_en && i_wr.d_idx == i_index) begin
            r_bx <= i_wr.d_bx;
        end
        if (i_wr.a_en && i_wr.a_idx == i_index) begin
            r_ly <= i_wr.a_ly;
        end else if (i_wr.b_en && i_wr.b_idx == i_index) begin
            r_ly <= i_wr.b_ly;
        end
    end

    // For a query with OK status, the first cell always supplies the fallback level; later active cells
    // override it when their boundary is at or below the query position.
    always_comb begin
        x_ext = {{(BX_W-DATA_W){i_tok.x[DATA_W-1]}}, i_tok.x};
        take  = (i_tok.status == ST_OK) &&
                ((i_index == '0) || ((i_index < i_entries) && (r_bx <= x_ext)));
        n_level = take ? r_ly : i_tok.level;
    end

    // Token stage toward the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x      <= i_tok.x;
            r_level  <= n_level;
            r_status <= i_tok.status;
        end
    end

    assign o_tok = '{valid: r_valid, x: r_x, level: r_level, status: r_status};

endmodule

FILE: rtl/core/pic_checker.sv
// Port-level checker for the interpolator, bound to the top level.
`include "assert_macros.svh"

module pic_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               i_action,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_level,
    input logic [1:0]         o_status
);
    import pic_pkg::*;

    // An error status always comes with a zero level.
    `ASSERT_IMPLIES(a_err_level_zero, i_clk, i_rst_n, o_out_valid && (o_status != ST_OK), o_level == 32'sd0, "error status with nonzero level")

    // A stalled result holds its value.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_level) && $stable(o_status), "stalled result changed")

    // Reset leaves no result pending.
    `ASSERT_NEXT_ANY(a_reset_empty, i_clk, !i_rst_n, !o_out_valid, "result pending after reset")

    // A query is never taken while the output is stalled.
    `ASSERT_IMPLIES(a_query_stall, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_action == ACT_QUERY), !(o_out_valid && !i_out_ready), "query taken while output stalled")

endmodule

bind piecewise_constant_interpolator_top pic_checker u_checker (.*);
